// ===== hdl/ipv4dq_pkg.sv =====
// Shared types, character codes and class codes for the IPv4 dotted-quad classifier.
package ipv4dq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [2:0] CLS_A = 3'd0;
	localparam logic [2:0] CLS_B = 3'd1;
	localparam logic [2:0] CLS_C = 3'd2;
	localparam logic [2:0] CLS_D = 3'd3;
	localparam logic [2:0] CLS_E = 3'd4;

	localparam logic [31:0] MASK_A = 32'hFF00_0000;
	localparam logic [31:0] MASK_B = 32'hFFFF_0000;
	localparam logic [31:0] MASK_C = 32'hFFFF_FF00;

	localparam logic [8:0] OCTET_SAT = 9'd256;
	localparam logic [8:0] OCTET_MAX = 9'd255;
	localparam logic [1:0] OCTETS_BEFORE_LAST = 2'd3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_word_t;

	typedef struct packed {
		logic        addr_valid;
		logic [31:0] address;
	} parsed_t;

	typedef struct packed {
		logic        addr_valid;
		logic [2:0]  addr_class;
		logic [31:0] address;
		logic        has_mask;
		logic [31:0] default_mask;
		logic [31:0] net_id;
		logic [31:0] host_id;
	} result_word_t;

endpackage

// ===== hdl/ipv4dq_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given type.
interface ipv4dq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ipv4dq_front.sv =====
// Character parser: per-octet state, finished-octet store, one word per string.
module ipv4dq_front
	import ipv4dq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	ipv4dq_stream_if.sink   chars,
	ipv4dq_stream_if.source parsed
);

	logic [1:0] octet_index_q, octet_index_n;
	logic [8:0] octet_accum_q, octet_accum_n;
	logic [1:0] digit_count_q, digit_count_n;
	logic       first_digit_zero_q, first_digit_zero_n;
	logic       parse_error_q, parse_error_n;
	logic [7:0] done_octets_q [3];

	logic        is_digit;
	logic [3:0]  digit_val;
	logic [11:0] product;
	logic        store_octet;
	logic        accept;
	logic        last;
	logic [7:0]  ch;

	assign ch     = chars.data.char_code;
	assign last   = chars.data.last_char;
	assign accept = chars.valid && chars.ready;

	// a non-last char never pushes, but holding it back keeps the ready simple
	assign chars.ready  = parsed.ready;
	assign parsed.valid = chars.valid && last;

	assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	assign digit_val = 4'(ch - CHAR_ZERO);
	// accum * 10 + digit, accum is at most 256
	assign product   = {octet_accum_q, 3'b000} + {2'b00, octet_accum_q, 1'b0} + {8'd0, digit_val};

	always_comb begin
		octet_index_n      = octet_index_q;
		octet_accum_n      = octet_accum_q;
		digit_count_n      = digit_count_q;
		first_digit_zero_n = first_digit_zero_q;
		parse_error_n      = parse_error_q;
		store_octet        = 1'b0;
		if (!parse_error_q) begin
			if (is_digit) begin
				if (digit_count_q != 2'd0 && first_digit_zero_q) begin
					parse_error_n = 1'b1;
				end else begin
					if (digit_count_q == 2'd0) begin
						first_digit_zero_n = (digit_val == 4'd0);
					end
					octet_accum_n = (product > 12'(OCTET_MAX)) ? OCTET_SAT : product[8:0];
					if (digit_count_q != 2'd3) begin
						digit_count_n = digit_count_q + 2'd1;
					end
				end
			end else if (ch == CHAR_DOT) begin
				if (digit_count_q == 2'd0 || octet_index_q == OCTETS_BEFORE_LAST ||
				    octet_accum_q > OCTET_MAX) begin
					parse_error_n = 1'b1;
				end else begin
					store_octet        = 1'b1;
					octet_index_n      = octet_index_q + 2'd1;
					octet_accum_n      = '0;
					digit_count_n      = '0;
					first_digit_zero_n = 1'b0;
				end
			end else begin
				parse_error_n = 1'b1;
			end
		end
	end

	always_comb begin
		parsed.data.addr_valid = !parse_error_n && octet_index_n == OCTETS_BEFORE_LAST &&
		                         digit_count_n != 2'd0 && octet_accum_n <= OCTET_MAX;
		parsed.data.address    = {done_octets_q[0], done_octets_q[1], done_octets_q[2],
		                          octet_accum_n[7:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_index_q      <= '0;
			octet_accum_q      <= '0;
			digit_count_q      <= '0;
			first_digit_zero_q <= 1'b0;
			parse_error_q      <= 1'b0;
		end else if (accept) begin
			if (last) begin
				octet_index_q      <= '0;
				octet_accum_q      <= '0;
				digit_count_q      <= '0;
				first_digit_zero_q <= 1'b0;
				parse_error_q      <= 1'b0;
			end else begin
				octet_index_q      <= octet_index_n;
				octet_accum_q      <= octet_accum_n;
				digit_count_q      <= digit_count_n;
				first_digit_zero_q <= first_digit_zero_n;
				parse_error_q      <= parse_error_n;
			end
		end
	end

	// store has no reset; entries are read only after all three were written
	always_ff @(posedge clk) begin
		if (accept && store_octet) begin
			done_octets_q[octet_index_q] <= octet_accum_q[7:0];
		end
	end

`ifndef SYNTH
	a_accum_sat: assert property (@(posedge clk) disable iff (!arst_n)
		octet_accum_q <= OCTET_SAT)
		else $error("octet accumulator beyond saturation value");
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (octet_index_q == 2'd0 && digit_count_q == 2'd0 && !parse_error_q))
		else $error("string state not cleared after final char");
	a_empty_part: assert property (@(posedge clk) disable iff (!arst_n)
		(digit_count_q == 2'd0) |-> (octet_accum_q == 9'd0 && !first_digit_zero_q))
		else $error("empty part holds a value");
`endif

endmodule

// ===== hdl/ipv4dq_queue.sv =====
// Short FIFO between the parser and the classifier.
module ipv4dq_queue
	import ipv4dq_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ipv4dq_stream_if.sink   push,
	ipv4dq_stream_if.source pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	parsed_t         entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign push.ready = (count_q != CW'(DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.data   = entry_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
`endif

endmodule

// ===== hdl/ipv4dq_back.sv =====
// Classful decode, mask and net/host split, with the output register.
module ipv4dq_back
	import ipv4dq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	ipv4dq_stream_if.sink   parsed,
	ipv4dq_stream_if.source result
);

	result_word_t word_d;
	result_word_t word_q;
	logic         valid_q;
	logic [7:0]   first;
	logic         load;

	assign first        = parsed.data.address[31:24];
	assign parsed.ready = !valid_q || result.ready;
	assign load         = parsed.valid && parsed.ready;
	assign result.valid = valid_q;
	assign result.data  = word_q;

	always_comb begin
		word_d              = '0;
		word_d.addr_valid   = parsed.data.addr_valid;
		if (parsed.data.addr_valid) begin
			word_d.address = parsed.data.address;
			// first octets 0 and 127 fall through to class E
			if (first inside {[8'd1:8'd126]}) begin
				word_d.addr_class   = CLS_A;
				word_d.default_mask = MASK_A;
			end else if (first inside {[8'd128:8'd191]}) begin
				word_d.addr_class   = CLS_B;
				word_d.default_mask = MASK_B;
			end else if (first inside {[8'd192:8'd223]}) begin
				word_d.addr_class   = CLS_C;
				word_d.default_mask = MASK_C;
			end else if (first inside {[8'd224:8'd239]}) begin
				word_d.addr_class   = CLS_D;
			end else begin
				word_d.addr_class   = CLS_E;
			end
			word_d.has_mask = (word_d.default_mask != '0);
			word_d.net_id   = parsed.data.address & word_d.default_mask;
			word_d.host_id  = word_d.has_mask ? (parsed.data.address & ~word_d.default_mask)
			                                  : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (parsed.ready) begin
			valid_q <= parsed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
		end
	end

endmodule

// ===== hdl/ipv4_dotted_quad_classifier.sv =====
// Top level: IPv4 dotted-quad text validator and classful classifier.
//
//  channel     dir  word             notes
//  char_in     in   char_word_t      one ASCII char, last_char on the final one
//  result_out  out  result_word_t    one word per string, after its final char
//
// One char per cycle while the queue has room; a new string may start the cycle after a final char.
// A final char's result word is registered in the queue and then in the output register.
// The parser stalls only when the queue is full; the queue fills only while
// result_out is held back, so each side stalls on its own.
// Reset (arst_n low) clears the parser state, the queue and the output valid.
module ipv4_dotted_quad_classifier
	import ipv4dq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF  // 2 to 32 entries
) (
	input  logic            clk,
	input  logic            arst_n,
	ipv4dq_stream_if.sink   char_in,
	ipv4dq_stream_if.source result_out
);

	// parser -> queue -> classifier
	ipv4dq_stream_if #(.T(parsed_t)) to_queue ();
	ipv4dq_stream_if #(.T(parsed_t)) from_queue ();

	// front: per-char octet parsing, emits validity and packed address
	ipv4dq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_in),
		.parsed (to_queue)
	);

	// decoupling queue
	ipv4dq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (to_queue),
		.pop    (from_queue)
	);

	// back: class, default mask, net and host IDs, registered out
	ipv4dq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.parsed (from_queue),
		.result (result_out)
	);

endmodule
